/* rtl/fms_pkg.sv */
// Shared constants and types for the frame median selector.
package fms_pkg;

    localparam int MAX_SAMPLES = 32;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int FCOUNT_W    = 6;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CNT_W-1:0]    count_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

/* rtl/fms_cell.sv */
// One storage cell of the sorted insertion chain.
module fms_cell (
    input  logic                clk,
    input  fms_pkg::cell_ctrl_t ctrl,
    input  fms_pkg::sample_t    sample,
    input  logic                occupied,
    input  logic                left_gt,
    input  fms_pkg::sample_t    left_value,
    input  fms_pkg::sample_t    right_value,
    output logic                gt,
    output fms_pkg::sample_t    value
);

    fms_pkg::sample_t value_reg;
    fms_pkg::sample_t value_next;

    // an empty cell acts as +infinity, so the new word lands after equal ones
    assign gt    = !occupied || (value_reg > sample);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (left_gt)
            begin
                value_next = left_value;
            end
            else if (gt)
            begin
                value_next = sample;
            end
        end
        else if (ctrl.drain)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* rtl/frame_median_select.sv */
// Frame median selector: sorted insertion chain with a drain-and-read sequencer.
//
// Input channel (in_valid / in_stall, sample, last_sample): one 16-bit word per
// accepted cycle. Each word is inserted into a row of MAX_SAMPLES cells kept in
// ascending order, one word per cycle, with no gaps while a frame is filling.
// Words arriving with the row already full are dropped and flagged as overflow.
// The word with last_sample set closes the frame.
//
// After the closing word the chain shifts toward cell 0 until the middle pair
// sits in cells 0 and 1, then the result is formed once the output register
// is free. Input stalls during that time; every other word is taken without
// a stall.
//
// Output channel (out_valid / out_stall, median, frame_count, overflow) is a
// register. A stalled result holds; new frame words are still taken meanwhile,
// and only the next frame end waits for the output register to free up.
//
// Reset clears the count, the overflow flag, the sequencer and out_valid.
module frame_median_select (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [15:0]                   sample,
    input  logic                          last_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   median,
    output logic [fms_pkg::FCOUNT_W-1:0]  frame_count,
    output logic                          overflow
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                 state_reg, state_next;
    fms_pkg::count_t        count_reg, count_next;
    fms_pkg::count_t        steps_reg, steps_next;
    logic                   dropped_reg, dropped_next;
    logic                   out_valid_reg, out_valid_next;
    fms_pkg::sample_t       median_reg, median_next;
    fms_pkg::count_t        fcount_reg, fcount_next;
    logic                   ovf_reg, ovf_next;

    fms_pkg::cell_ctrl_t    ctrl;
    logic                   accept;
    logic                   has_room;
    logic                   out_free;
    fms_pkg::count_t        count_after;
    logic [fms_pkg::SAMPLE_W:0] pair_sum;

    fms_pkg::sample_t       cell_value [fms_pkg::MAX_SAMPLES];
    logic                   cell_gt    [fms_pkg::MAX_SAMPLES];
    logic                   cell_occ   [fms_pkg::MAX_SAMPLES];

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign has_room = count_reg < fms_pkg::count_t'(fms_pkg::MAX_SAMPLES);
    assign out_free = !out_valid_reg || !out_stall;

    assign ctrl.insert = accept && has_room;
    assign ctrl.drain  = (state_reg == ST_DRAIN) && (steps_reg != '0);

    assign count_after = has_room ? count_reg + fms_pkg::count_t'(1) : count_reg;
    assign pair_sum    = {1'b0, cell_value[0]} + {1'b0, cell_value[1]};

    genvar i;
    generate
        for (i = 0; i < fms_pkg::MAX_SAMPLES; i++)
        begin : g_cell
            fms_pkg::sample_t left_v;
            fms_pkg::sample_t right_v;
            logic             left_g;

            assign cell_occ[i] = fms_pkg::count_t'(i) < count_reg;

            if (i == 0)
            begin : g_first
                assign left_v = sample;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_v = cell_value[i-1];
                assign left_g = cell_gt[i-1];
            end

            if (i == fms_pkg::MAX_SAMPLES - 1)
            begin : g_end
                assign right_v = cell_value[i];
            end
            else
            begin : g_inner
                assign right_v = cell_value[i+1];
            end

            fms_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .sample      (sample),
                .occupied    (cell_occ[i]),
                .left_gt     (left_g),
                .left_value  (left_v),
                .right_value (right_v),
                .gt          (cell_gt[i]),
                .value       (cell_value[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        fcount_next    = fcount_reg;
        ovf_next       = ovf_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_after;
                    if (!has_room)
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_sample)
                    begin
                        // shifts needed to bring the middle pair to cells 0 and 1
                        steps_next = (count_after - fms_pkg::count_t'(1)) >> 1;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (steps_reg != '0)
                begin
                    steps_next = steps_reg - fms_pkg::count_t'(1);
                end
                else if (out_free)
                begin
                    median_next    = count_reg[0] ? cell_value[0] : pair_sum[fms_pkg::SAMPLE_W:1];
                    fcount_next    = count_reg;
                    ovf_next       = dropped_reg;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    dropped_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            steps_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            median_reg    <= '0;
            fcount_reg    <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            steps_reg     <= steps_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            median_reg    <= median_next;
            fcount_reg    <= fcount_next;
            ovf_reg       <= ovf_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign median      = median_reg;
    assign frame_count = fms_pkg::FCOUNT_W'(fcount_reg);
    assign overflow    = ovf_reg;

endmodule

/* rtl/fms_checker.sv */
// Port-level checks for the frame median selector, bound to the top level.
module fms_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          last_sample,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [15:0]                   median,
    input  logic [fms_pkg::FCOUNT_W-1:0]  frame_count,
    input  logic                          overflow
);

    // a closing word always starts the drain, so input stalls next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_sample |=> in_stall)
        else $error("input not stalled after frame end");

    // every frame holds at least its closing word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_count != '0)
        else $error("result with empty frame");

    // dropping only happens with the row full
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            frame_count == fms_pkg::FCOUNT_W'(fms_pkg::MAX_SAMPLES))
        else $error("overflow with row not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median) && $stable(frame_count))
        else $error("stalled result changed");

endmodule

bind frame_median_select fms_checker u_fms_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .median      (median),
    .frame_count (frame_count),
    .overflow    (overflow)
);

/* tb/median_checker.sv */
// Channel monitor for frame_median_select: sorted-frame predictor and result scoreboard.
module median_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [15:0]                  sample,
    input  logic                         last_sample,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [15:0]                  median,
    input  logic [fms_pkg::FCOUNT_W-1:0] frame_count,
    input  logic                         overflow,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        fms_pkg::sample_t             med;
        logic [fms_pkg::FCOUNT_W-1:0] cnt;
        logic                         ovf;
    } frame_result_t;

    frame_result_t    result_q[$];
    fms_pkg::sample_t sorted_vals[fms_pkg::MAX_SAMPLES];
    int               held_n;
    logic             dropped;
    int               errs;

    always @(posedge clk or negedge rst_n)
    begin : watch
        int                         pos;
        logic [fms_pkg::SAMPLE_W:0] pair_sum;
        fms_pkg::sample_t           mid;
        frame_result_t              want;
        if (!rst_n)
        begin
            held_n = 0;
            dropped = 1'b0;
            errs = 0;
            result_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // check output first so a word pushed at this edge cannot match it
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got %h/%0d/%b",
                             $time, median, frame_count, overflow);
                    errs++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (median !== want.med)
                    begin
                        $display("%0t: median expected %h got %h", $time, want.med, median);
                        errs++;
                    end
                    if (frame_count !== want.cnt)
                    begin
                        $display("%0t: frame_count expected %0d got %0d",
                                 $time, want.cnt, frame_count);
                        errs++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $display("%0t: overflow expected %b got %b", $time, want.ovf, overflow);
                        errs++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (held_n < fms_pkg::MAX_SAMPLES)
                begin
                    // equal words stay ahead of the new one
                    pos = held_n;
                    while (pos > 0 && sorted_vals[pos-1] > sample)
                    begin
                        sorted_vals[pos] = sorted_vals[pos-1];
                        pos--;
                    end
                    sorted_vals[pos] = sample;
                    held_n++;
                end
                else
                    dropped = 1'b1;

                if (last_sample)
                begin
                    if (held_n[0])
                        mid = sorted_vals[held_n/2];
                    else
                    begin
                        pair_sum = {1'b0, sorted_vals[held_n/2-1]}
                                 + {1'b0, sorted_vals[held_n/2]};
                        mid = pair_sum[fms_pkg::SAMPLE_W:1];
                    end
                    want.med = mid;
                    want.cnt = fms_pkg::FCOUNT_W'(held_n);
                    want.ovf = dropped;
                    result_q.push_back(want);
                    held_n = 0;
                    dropped = 1'b0;
                end
            end

            fail_count <= errs;
            pending <= result_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Top-level testbench for frame_median_select: clock, reset, frame stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [15:0]                  sample;
    logic                         last_sample;
    logic                         out_valid;
    logic                         out_stall;
    logic [15:0]                  median;
    logic [fms_pkg::FCOUNT_W-1:0] frame_count;
    logic                         overflow;
    int                           fail_count;
    int                           pending;

    int tx_idle_pct;
    int rx_idle_pct;
    int words_sent;
    int frames_sent;
    int wide_frames;

    frame_median_select u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .median      (median),
        .frame_count (frame_count),
        .overflow    (overflow)
    );

    median_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .median      (median),
        .frame_count (frame_count),
        .overflow    (overflow),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // receiver back-pressure
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic fms_pkg::sample_t pick_value();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return fms_pkg::sample_t'($urandom_range(3));
            3:       return fms_pkg::sample_t'($urandom_range(65535, 65532));
            default: return fms_pkg::sample_t'($urandom_range(65535, 0));
        endcase
    endfunction

    task automatic send_word(input fms_pkg::sample_t s, input logic l);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        last_sample <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (l)
            frames_sent++;
    endtask

    task automatic send_random_frame();
        int len;
        // mostly short frames, some around and past the store size
        if ($urandom_range(99) < 12)
            len = $urandom_range(40, 29);
        else
            len = $urandom_range(12, 1);
        if (len > fms_pkg::MAX_SAMPLES)
            wide_frames++;
        for (int i = 0; i < len; i++)
            send_word(pick_value(), i == len - 1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        in_valid <= 1'b0;
        sample <= '0;
        last_sample <= 1'b0;
        rst_n <= 1'b0;
        tx_idle_pct = 26;
        rx_idle_pct <= 62;
        words_sent = 0;
        frames_sent = 0;
        wide_frames = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-word frames at both extremes
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0000, 1'b1);
        // even pairs: full 17-bit sum, and floor of odd sum
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h0001, 1'b1);
        // repeated words, then a descending run
        send_word(16'h0005, 1'b0);
        send_word(16'h0005, 1'b0);
        send_word(16'h0003, 1'b1);
        send_word(16'h0009, 1'b0);
        send_word(16'h0007, 1'b0);
        send_word(16'h0003, 1'b0);
        send_word(16'h0001, 1'b1);
        send_word(16'hAAAA, 1'b0);
        send_word(16'h5555, 1'b1);

        while (words_sent < 480)
            send_random_frame();
        drain_results();

        tx_idle_pct = 62;
        rx_idle_pct <= 26;
        while (words_sent < 960)
            send_random_frame();
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        while (words_sent < 1450)
            send_random_frame();

        drain_results();
        repeat (40) @(posedge clk);

        $display("tb_top: %0d words in %0d frames, %0d frames ran past the %0d-word store",
                 words_sent, frames_sent, wide_frames, fms_pkg::MAX_SAMPLES);
        $display("tb_top: idle mixes sender/receiver 26/62, 62/26 and 0/0");
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
